@@ src/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types, widths and helpers of the longest prefix route lookup core
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 4;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned LEN_W  = 6;

    // depth of the queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] entry_index;
        logic              entry_valid;
        logic [ADDR_W-1:0] net_addr;
        logic [ADDR_W-1:0] net_mask;
        logic [ADDR_W-1:0] gateway_addr;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] dest_addr;
    } t_in_beat;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] next_hop;
        logic [PORT_W-1:0] egress_port;
        logic [SLOT_W-1:0] match_slot;
    } t_out_beat;

    // one table row as stored
    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  len;
    } t_route;

    // classified work item handed from front to back
    typedef struct packed {
        logic              is_lookup;
        logic              slot_valid;
        logic [SLOT_W-1:0] slot;
        t_route            route;
        logic [ADDR_W-1:0] dest;
    } t_work;

    // prefix length: one bits of the mask, counted per byte then summed
    function automatic logic [LEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
        logic [3:0] cnt [4];
        for (int b = 0; b < 4; b++) begin
            cnt[b] = '0;
            for (int k = 0; k < 8; k++) begin
                cnt[b] = cnt[b] + 4'(v[b*8+k]);
            end
        end
        return (LEN_W'(cnt[0]) + LEN_W'(cnt[1])) + (LEN_W'(cnt[2]) + LEN_W'(cnt[3]));
    endfunction

endpackage

@@ src/lpr_front.sv @@
// ----------------------------------------------------------------------------
// lpr_front
// takes input beats, drops out-of-range loads, saturates the port and
// computes the prefix length before queuing
// ----------------------------------------------------------------------------
module lpr_front #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned PORT_COUNT    = 16
) (
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lpr_pkg::t_in_beat i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output lpr_pkg::t_work   o_work
);
    import lpr_pkg::*;

    logic slot_ok;
    logic port_over;

    assign slot_ok   = int'(i_in.entry_index) < TABLE_ENTRIES;
    assign port_over = int'(i_in.out_port) >= PORT_COUNT;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && ((i_in.action == ACT_LOOKUP) || slot_ok);

    always_comb begin
        o_work.is_lookup     = (i_in.action == ACT_LOOKUP);
        o_work.slot_valid    = i_in.entry_valid;
        o_work.slot          = i_in.entry_index;
        o_work.route.net     = i_in.net_addr;
        o_work.route.mask    = i_in.net_mask;
        o_work.route.gateway = i_in.gateway_addr;
        o_work.route.port    = port_over ? PORT_W'(PORT_COUNT - 1) : i_in.out_port;
        o_work.route.len     = ones_in(i_in.net_mask);
        o_work.dest          = i_in.dest_addr;
    end

endmodule

@@ src/lpr_queue.sv @@
// ----------------------------------------------------------------------------
// lpr_queue
// short fifo of work items between front and back
// ----------------------------------------------------------------------------
module lpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpr_pkg::t_work i_work,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lpr_pkg::t_work o_head
);
    import lpr_pkg::*;

    t_work              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/lpr_back.sv @@
// ----------------------------------------------------------------------------
// lpr_back
// holds the route table and runs loads and lookups; a lookup scans the
// table one row per cycle through a registered read port
// ----------------------------------------------------------------------------
module lpr_back #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  lpr_pkg::t_work     i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpr_pkg::t_out_beat o_out
);
    import lpr_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_EMIT} t_state;

    t_state                    r_state;
    t_route                    r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  r_slot_used;
    t_route                    r_rd;
    logic                      r_pv;
    logic                      r_pv_used;
    logic [AW-1:0]             r_pv_slot;
    logic [AW-1:0]             r_addr;
    logic [ADDR_W-1:0]         r_dest;
    logic                      r_hit;
    logic [LEN_W-1:0]          r_best_len;
    logic [AW-1:0]             r_best_slot;
    logic [ADDR_W-1:0]         r_best_gw;
    logic [PORT_W-1:0]         r_best_port;
    t_out_beat                 r_out;
    logic                      r_out_valid;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic          out_free;
    logic          entry_hit;
    logic          take;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign wr_en     = o_pop && !i_head.is_lookup;
    assign wr_addr   = AW'(i_head.slot);
    assign rd_en     = (r_state == S_SCAN);
    assign out_free  = !r_out_valid || i_out_ready;
    assign entry_hit = r_pv && r_pv_used && ((r_dest & r_rd.mask) == r_rd.net);
    // strictly longer wins, so ties stay with the lower slot
    assign take      = entry_hit && (!r_hit || (r_rd.len > r_best_len));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_head.route;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_used <= '0;
        end else if (wr_en) begin
            r_slot_used[wr_addr] <= i_head.slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv      <= rd_en;
            r_pv_used <= r_slot_used[r_addr];
            r_pv_slot <= r_addr;
            if (take) begin
                r_hit       <= 1'b1;
                r_best_len  <= r_rd.len;
                r_best_slot <= r_pv_slot;
                r_best_gw   <= r_rd.gateway;
                r_best_port <= r_rd.port;
            end
            // in S_EMIT the output register is reloaded below instead
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_head.is_lookup) begin
                        r_dest     <= i_head.dest;
                        r_addr     <= '0;
                        r_hit      <= 1'b0;
                        r_best_len <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LastAddr) begin
                        r_state <= S_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_LAST: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.found       <= r_hit;
                        r_out.next_hop    <= r_hit ? r_best_gw : '0;
                        r_out.egress_port <= r_hit ? r_best_port : '0;
                        r_out.match_slot  <= r_hit ? SLOT_W'(r_best_slot) : '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("read data pending while idle");

    a_winner_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_hit) |-> r_slot_used[r_best_slot])
        else $error("winning slot is not in use");

    a_scan_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_addr != LastAddr) |=> (r_state == S_SCAN))
        else $error("scan left before the last slot");

    a_last_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |=> (r_state == S_EMIT))
        else $error("last row not followed by result");

endmodule

@@ src/longest_prefix_route_lookup_core.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_core
// ipv4 route table with longest prefix match lookup
// ----------------------------------------------------------------------------
//  channel  | valid / ready             | payload
//  ---------+---------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready   | i_in  (load or lookup beat)
//  out      | o_out_valid / i_out_ready | o_out (found, hop, port, slot)
//
//  a load gives no result beat
//  a lookup steps the back end through scan, last and emit: the table has a
//  single read port and is scanned one row per cycle
//  reset clears all in-use flags at once; table data is undefined until loaded
//  a 2-beat queue lets input beats arrive while the back end scans
//  a stalled output beat holds the back end only when the next result is due
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_core #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned PORT_COUNT    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpr_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpr_pkg::t_out_beat o_out
);
    import lpr_pkg::*;

    // front to queue
    logic  q_push;
    t_work q_in;
    logic  q_full;
    // queue to back
    logic  q_pop;
    logic  q_empty;
    t_work q_head;

    // classify: out-of-range loads are dropped here, prefix length precomputed
    lpr_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_work     (q_in)
    );

    // decouples input acceptance from the table scan
    lpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // table, scan sequencer and output register
    lpr_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
